// ===== sv/stream_metadata_field_parser_assert.svh =====
// Assertion macros for the stream metadata field parser.
`ifndef STREAM_METADATA_FIELD_PARSER_ASSERT_SVH
`define STREAM_METADATA_FIELD_PARSER_ASSERT_SVH

`ifndef SYNTH

// Clocked check, masked while reset is asserted.
`define SMFP_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("smfp assertion failed");

// Clocked check that also holds during reset.
`define SMFP_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("smfp assertion failed");

`else

`define SMFP_ASSERT(name, prop)
`define SMFP_ASSERT_ALWAYS(name, prop)

`endif

`endif

// ===== sv/smfp_pkg.sv =====
// Types and constants shared by the stream metadata field parser.
package smfp_pkg;

  localparam int MaxRes = 4;                 // results per input byte, at most
  localparam int CntW   = $clog2(MaxRes + 1);
  localparam int IdxW   = $clog2(MaxRes);
  localparam int QDepth = 4;                 // front-to-back queue entries
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChEq     = 8'h3D;
  localparam logic [7:0] ChPlus   = 8'h2B;

  typedef enum logic [1:0] {
    KIND_KEY   = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_END   = 2'd2,
    KIND_ERROR = 2'd3
  } item_kind_e;

  typedef enum logic [2:0] {
    PH_KEY_START  = 3'd0,
    PH_KEY        = 3'd1,
    PH_WAIT_QUOTE = 3'd2,
    PH_VALUE      = 3'd3,
    PH_QUOTE_HELD = 3'd4,
    PH_SEMI_HELD  = 3'd5,
    PH_DISCARD    = 3'd6
  } phase_e;

  typedef struct packed {
    item_kind_e kind;
    logic [7:0] data;
  } slot_t;

  // All results caused by one input byte.
  typedef struct packed {
    slot_t [MaxRes-1:0] slots;
    logic [CntW-1:0]    count;
    logic               last;   // byte closed the block
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

// ===== sv/smfp_if.sv =====
// Stream channel interfaces for input bytes and parse results.
interface smfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       block_last;

  modport source (output valid, output data_byte, output block_last, input ready);
  modport sink   (input valid, input data_byte, input block_last, output ready);
endinterface

interface smfp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] item_kind;
  logic [7:0] out_byte;
  logic       block_done;
  logic       run_last;

  modport source (output valid, output item_kind, output out_byte, output block_done,
                  output run_last, input ready);
  modport sink   (input valid, input item_kind, input out_byte, input block_done,
                  input run_last, output ready);
endinterface

// ===== sv/smfp_front.sv =====
// Front end: accepts bytes, runs the parse state machine, builds result entries.
module smfp_front import smfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] data_byte_i,
  input  logic       block_last_i,
  input  q_status_t  q_status_i,
  output logic       in_ready_o,
  output logic       push_o,
  output entry_t     entry_o
);

  phase_e     phase_q, phase_d, hphase;
  logic       dq_q, dq_d, dq_h;
  logic       accept;
  logic       is_letter, is_quote, is_close, is_semi, is_eq, is_plus;
  logic [7:0] close_ch;
  logic [CntW-1:0] n;
  entry_t     ent;

  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;

  assign close_ch  = dq_q ? ChDquote : ChSquote;
  assign is_letter = data_byte_i inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  assign is_quote  = (data_byte_i == ChSquote) || (data_byte_i == ChDquote);
  assign is_close  = (data_byte_i == close_ch);
  assign is_semi   = (data_byte_i == ChSemi);
  assign is_eq     = (data_byte_i == ChEq);
  assign is_plus   = (data_byte_i == ChPlus);

  // Next state. hphase is the phase after the byte, before block end applies.
  always_comb begin
    hphase = PH_DISCARD;
    dq_h   = dq_q;
    case (phase_q)
      PH_KEY_START: hphase = is_letter ? PH_KEY : PH_DISCARD;
      PH_KEY: begin
        if (is_letter) hphase = PH_KEY;
        else if (is_eq) hphase = PH_WAIT_QUOTE;
        else hphase = PH_DISCARD;
      end
      PH_WAIT_QUOTE: begin
        if (is_quote) begin
          hphase = PH_VALUE;
          dq_h   = (data_byte_i == ChDquote);
        end else begin
          hphase = PH_DISCARD;
        end
      end
      PH_VALUE: hphase = is_close ? PH_QUOTE_HELD : PH_VALUE;
      PH_QUOTE_HELD: begin
        if (is_semi) hphase = PH_SEMI_HELD;
        else hphase = is_close ? PH_QUOTE_HELD : PH_VALUE;
      end
      PH_SEMI_HELD: begin
        if (is_letter) hphase = PH_KEY;
        else if (is_plus || is_eq) hphase = PH_DISCARD;
        else hphase = is_close ? PH_QUOTE_HELD : PH_VALUE;
      end
      default: hphase = PH_DISCARD;
    endcase
    phase_d = block_last_i ? PH_KEY_START : hphase;
    dq_d    = block_last_i ? 1'b0 : dq_h;
  end

  // Results for the byte.
  always_comb begin
    ent = '0;
    n   = '0;
    case (phase_q)
      PH_KEY_START: begin
        ent.slots[0] = is_letter ? slot_t'{KIND_KEY, data_byte_i} : slot_t'{KIND_ERROR, 8'h00};
        n = CntW'(1);
      end
      PH_KEY: begin
        if (is_letter) begin
          ent.slots[0] = slot_t'{KIND_KEY, data_byte_i};
          n = CntW'(1);
        end else if (!is_eq) begin
          ent.slots[0] = slot_t'{KIND_ERROR, 8'h00};
          n = CntW'(1);
        end
      end
      PH_WAIT_QUOTE: begin
        if (!is_quote) begin
          ent.slots[0] = slot_t'{KIND_ERROR, 8'h00};
          n = CntW'(1);
        end
      end
      PH_VALUE: begin
        if (!is_close) begin
          ent.slots[0] = slot_t'{KIND_VALUE, data_byte_i};
          n = CntW'(1);
        end
      end
      PH_QUOTE_HELD: begin
        if (!is_semi) begin
          ent.slots[0] = slot_t'{KIND_VALUE, close_ch};
          ent.slots[1] = slot_t'{KIND_VALUE, data_byte_i};
          n = is_close ? CntW'(1) : CntW'(2);
        end
      end
      PH_SEMI_HELD: begin
        if (is_letter) begin
          ent.slots[0] = slot_t'{KIND_END, 8'h00};
          ent.slots[1] = slot_t'{KIND_KEY, data_byte_i};
          n = CntW'(2);
        end else if (is_plus || is_eq) begin
          ent.slots[0] = slot_t'{KIND_END, 8'h00};
          ent.slots[1] = slot_t'{KIND_ERROR, 8'h00};
          n = CntW'(2);
        end else begin
          ent.slots[0] = slot_t'{KIND_VALUE, close_ch};
          ent.slots[1] = slot_t'{KIND_VALUE, ChSemi};
          ent.slots[2] = slot_t'{KIND_VALUE, data_byte_i};
          n = is_close ? CntW'(2) : CntW'(3);
        end
      end
      default: n = '0;
    endcase
    // Block end: a held quote closes the field, anything else unfinished fails.
    if (block_last_i && (phase_q inside {[PH_KEY_START:PH_SEMI_HELD]}) &&
        (hphase != PH_DISCARD)) begin
      ent.slots[n[IdxW-1:0]] = (hphase inside {PH_QUOTE_HELD, PH_SEMI_HELD}) ?
                               slot_t'{KIND_END, 8'h00} : slot_t'{KIND_ERROR, 8'h00};
      n = n + CntW'(1);
    end
    ent.count = n;
    ent.last  = block_last_i;
  end

  assign entry_o = ent;
  assign push_o  = accept && (ent.count != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_KEY_START;
      dq_q    <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      dq_q    <= dq_d;
    end
  end

endmodule

// ===== sv/smfp_queue.sv =====
// Small FIFO of result entries between front and back.
module smfp_queue import smfp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  entry_t    entry_i,
  input  logic      pop_i,
  output entry_t    head_o,
  output q_status_t status_o
);

  entry_t             mem_q [QDepth];
  logic [QPtrW-1:0]   wr_q, rd_q;
  logic [QCntW-1:0]   cnt_q;

  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == QCntW'(QDepth));
  assign head_o         = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + QPtrW'(1);
      if (pop_i)  rd_q <= rd_q + QPtrW'(1);
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + QCntW'(1);
        2'b01:   cnt_q <= cnt_q - QCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== sv/smfp_back.sv =====
// Back end: walks the results of the head entry, one transfer per cycle while out_ready_i is high.
module smfp_back import smfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  entry_t     head_i,
  input  q_status_t  q_status_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] item_kind_o,
  output logic [7:0] out_byte_o,
  output logic       block_done_o,
  output logic       run_last_o
);

  logic [IdxW-1:0] sub_q, sub_d;
  logic            fire, last_res;
  slot_t           cur;

  assign cur      = head_i.slots[sub_q];
  assign last_res = ((CntW'(sub_q) + CntW'(1)) == head_i.count);
  assign fire     = out_valid_o && out_ready_i;
  assign pop_o    = fire && last_res;

  assign out_valid_o  = !q_status_i.empty;
  assign item_kind_o  = cur.kind;
  assign out_byte_o   = cur.data;
  assign run_last_o   = last_res;
  assign block_done_o = (cur.kind == KIND_ERROR) || (head_i.last && last_res);

  always_comb begin
    sub_d = sub_q;
    if (fire) sub_d = last_res ? '0 : sub_q + IdxW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sub_q <= '0;
    else         sub_q <= sub_d;
  end

endmodule

// ===== sv/stream_metadata_field_parser.sv =====
// Top level of the stream metadata field parser.
// Parses one metadata block, a byte per transfer on in_i with block_last on the
// final byte, as fields key='value'; or key="value"; and sends key bytes, value
// bytes, field-end marks and at most one error per block on out_o. The front end
// takes a byte in every cycle while its four-entry result queue has room; results
// reach out_o through that registered queue. A byte causes zero to four results;
// the back end sends one result per cycle while out_o is ready, so a byte with k
// results takes k transfers and the sustained input rate is set by the single
// output port. A closing quote and the ';' after it are held inside the state
// machine until the next byte or the block end shows whether they close the value.
// After an error, bytes give no results until block_last, then parsing starts
// over at a key. run_last marks the last result of each byte, block_done the
// result that closes the block.
module stream_metadata_field_parser import smfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  smfp_in_if.sink     in_i,
  smfp_out_if.source  out_o
);

`include "stream_metadata_field_parser_assert.svh"

  entry_t    entry, head;
  q_status_t q_status;
  logic      push, pop;

  // Front: accept and classify, one byte per transfer.
  smfp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .data_byte_i  (in_i.data_byte),
    .block_last_i (in_i.block_last),
    .q_status_i   (q_status),
    .in_ready_o   (in_i.ready),
    .push_o       (push),
    .entry_o      (entry)
  );

  // Queue decouples input stalls from output stalls.
  smfp_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (entry),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  // Back: unpack each entry into single-result transfers.
  smfp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .q_status_i   (q_status),
    .pop_o        (pop),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .item_kind_o  (out_o.item_kind),
    .out_byte_o   (out_o.out_byte),
    .block_done_o (out_o.block_done),
    .run_last_o   (out_o.run_last)
  );

  // Queue never written while full.
  `SMFP_ASSERT(a_no_overflow, push |-> !q_status.full)
  // Queue never popped while empty.
  `SMFP_ASSERT(a_no_underflow, pop |-> !q_status.empty)
  // Block-closing result is always the last of its byte.
  `SMFP_ASSERT(a_done_is_last, (out_o.valid && out_o.block_done) |-> out_o.run_last)
  // Errors always close the block.
  `SMFP_ASSERT(a_error_done,
    (out_o.valid && (out_o.item_kind == KIND_ERROR)) |-> out_o.block_done)

endmodule
